// ===== rtl/fpms_pkg.sv =====
package fpms_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int REQ_W      = 4;
    localparam int TRIG_W     = 16;
    localparam int IDX_W      = 4;
    localparam int LEVEL_W    = 5;
    localparam int CFG_ADDR_W = 4;

    // Matrix geometry: 3 rows of 4 elements, row-major
    localparam int ELEMS   = 12;
    localparam int ROWS    = 3;
    localparam int ROW_LEN = 4;

    // Defaults for the top-level parameters
    localparam int DEF_STACK_DEPTH   = 32;
    localparam int DEF_FRACTION_BITS = 14;

    // Command codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH      = 4'd0,
        REQ_PUSH_ID   = 4'd1,
        REQ_POP       = 4'd2,
        REQ_LOAD      = 4'd3,
        REQ_TRANS_REL = 4'd4,
        REQ_TRANS_ABS = 4'd5,
        REQ_ROT_X     = 4'd6,
        REQ_ROT_Y     = 4'd7,
        REQ_ROT_Z     = 4'd8,
        REQ_SCALE     = 4'd9,
        REQ_READ      = 4'd10
    } t_req;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_VIEW_X = 2'd0,
        REG_VIEW_Y = 2'd1,
        REG_VIEW_Z = 2'd2
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_IDENT,
        ST_ROW_LOAD,
        ST_ROW_MAC,
        ST_RD_ISSUE,
        ST_RD_EMIT,
        ST_STATUS
    } t_state;

    // Multiplier coefficient source
    typedef enum logic [2:0] {
        COEF_X,
        COEF_Y,
        COEF_Z,
        COEF_C,
        COEF_S
    } t_coef;

    // One micro-op of the per-row multiply-accumulate program
    typedef struct packed {
        logic [1:0] src_col;  // row buffer element fed to the multiplier
        t_coef      coef;
        logic       first;    // accumulator starts from the init value
        logic       sub;      // subtract the product
        logic       wr;       // write the accumulated result back
        logic       shift;    // arithmetic shift by the fraction bits on write
        logic [1:0] wcol;     // column written back
        logic       done;     // last micro-op of the row
    } t_uop;

    // Control traveling with a product through the MAC pipeline
    typedef struct packed {
        logic       first;
        logic       sub;
        logic       wr;
        logic       shift;
        logic [1:0] row;
        logic [1:0] col;
    } t_mac_ctl;

    // Write-back request from the MAC unit
    typedef struct packed {
        logic               en;
        logic [1:0]         row;
        logic [1:0]         col;
        logic [VALUE_W-1:0] data;
    } t_mac_wr;

    function automatic t_uop uop_make(logic [1:0] src, t_coef coef, logic first, logic sub,
                                      logic wr, logic shift, logic [1:0] wcol, logic done);
        t_uop u;
        u.src_col = src;
        u.coef    = coef;
        u.first   = first;
        u.sub     = sub;
        u.wr      = wr;
        u.shift   = shift;
        u.wcol    = wcol;
        u.done    = done;
        return u;
    endfunction

    // Per-row program for translate, rotate and scale
    function automatic t_uop uop_decode(t_req req, logic [2:0] step);
        t_uop       u;
        logic [1:0] a;
        logic [1:0] b;
        u = uop_make(2'd0, COEF_X, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1);
        a = 2'd0;
        b = 2'd1;
        case (req)
            REQ_TRANS_REL, REQ_TRANS_ABS: begin
                // m3 (+)= x*m0 + y*m1 + z*m2, no shift
                case (step)
                    3'd0:    u = uop_make(2'd0, COEF_X, 1'b1, 1'b0, 1'b0, 1'b0, 2'd3, 1'b0);
                    3'd1:    u = uop_make(2'd1, COEF_Y, 1'b0, 1'b0, 1'b0, 1'b0, 2'd3, 1'b0);
                    default: u = uop_make(2'd2, COEF_Z, 1'b0, 1'b0, 1'b1, 1'b0, 2'd3, 1'b1);
                endcase
            end
            REQ_SCALE: begin
                case (step)
                    3'd0:    u = uop_make(2'd0, COEF_X, 1'b1, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0);
                    3'd1:    u = uop_make(2'd1, COEF_Y, 1'b1, 1'b0, 1'b1, 1'b1, 2'd1, 1'b0);
                    default: u = uop_make(2'd2, COEF_Z, 1'b1, 1'b0, 1'b1, 1'b1, 2'd2, 1'b1);
                endcase
            end
            REQ_ROT_X, REQ_ROT_Y, REQ_ROT_Z: begin
                // a' = c*a + s*b, b' = c*b - s*a
                case (req)
                    REQ_ROT_X: begin
                        a = 2'd1;
                        b = 2'd2;
                    end
                    REQ_ROT_Y: begin
                        a = 2'd0;
                        b = 2'd2;
                    end
                    default: begin
                        a = 2'd0;
                        b = 2'd1;
                    end
                endcase
                case (step)
                    3'd0:    u = uop_make(a, COEF_C, 1'b1, 1'b0, 1'b0, 1'b0, a, 1'b0);
                    3'd1:    u = uop_make(b, COEF_S, 1'b0, 1'b0, 1'b1, 1'b1, a, 1'b0);
                    3'd2:    u = uop_make(b, COEF_C, 1'b1, 1'b0, 1'b0, 1'b0, b, 1'b0);
                    default: u = uop_make(a, COEF_S, 1'b0, 1'b1, 1'b1, 1'b1, b, 1'b1);
                endcase
            end
            default: u = uop_make(2'd0, COEF_X, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/fpms_req_if.sv =====
interface fpms_req_if;
    import fpms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [TRIG_W-1:0]  sine_value;
    logic signed [TRIG_W-1:0]  cosine_value;
    logic signed [VALUE_W-1:0] vec_x;
    logic signed [VALUE_W-1:0] vec_y;
    logic signed [VALUE_W-1:0] vec_z;
    logic [IDX_W-1:0]          element_index;
    logic signed [VALUE_W-1:0] element_value;

    modport source (
        output valid, req_type, sine_value, cosine_value, vec_x, vec_y, vec_z,
               element_index, element_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, sine_value, cosine_value, vec_x, vec_y, vec_z,
               element_index, element_value,
        output ready
    );
endinterface

// ===== rtl/fpms_rsp_if.sv =====
interface fpms_rsp_if;
    import fpms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          out_index;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
    logic [LEVEL_W-1:0]        stack_level;
    logic                      stack_error;

    modport source (
        output valid, out_index, out_value, out_last, stack_level, stack_error,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_value, out_last, stack_level, stack_error,
        output ready
    );
endinterface

// ===== rtl/fpms_mac.sv =====
module fpms_mac #(
    parameter int FRACTION_BITS = fpms_pkg::DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue,
    input  fpms_pkg::t_mac_ctl            i_ctl,
    input  logic [fpms_pkg::VALUE_W-1:0]  i_mult_a,
    input  logic [fpms_pkg::VALUE_W-1:0]  i_mult_b,
    input  logic [fpms_pkg::VALUE_W-1:0]  i_init,
    output fpms_pkg::t_mac_wr             o_wr
);
    import fpms_pkg::*;

    logic                      r_valid;
    t_mac_ctl                  r_ctl;
    logic [VALUE_W-1:0]        r_prod;
    logic [VALUE_W-1:0]        r_init;
    logic [VALUE_W-1:0]        r_acc;
    logic [VALUE_W-1:0]        sum_base;
    logic [VALUE_W-1:0]        sum;
    logic signed [VALUE_W-1:0] sum_shr;

    // Stage 1: wrapping 32-bit product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_prod <= i_mult_a * i_mult_b;
            r_ctl  <= i_ctl;
            r_init <= i_init;
        end
    end

    // Stage 2: accumulate
    assign sum_base = r_ctl.first ? r_init : r_acc;
    assign sum      = r_ctl.sub ? (sum_base - r_prod) : (sum_base + r_prod);
    assign sum_shr  = $signed(sum) >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_acc <= sum;
        end
    end

    // Write-back request
    always_comb begin
        o_wr.en   = r_valid && r_ctl.wr;
        o_wr.row  = r_ctl.row;
        o_wr.col  = r_ctl.col;
        o_wr.data = r_ctl.shift ? sum_shr : sum;
    end

endmodule

// ===== rtl/fixed_point_matrix_stack.sv =====
// Channel   Role   Handshake      Carries
// i_req     sink   valid/ready    command, sine/cosine, vector, element index/value
// o_rsp     source valid/ready    element index/value, last, stack level, error
// apb       slave  psel/penable   view origin x/y/z at 0x0, 0x4, 0x8
//
// One command at a time, accepted only while the sequencer is idle. How long the
// sequencer stays busy after acceptance follows from the single memory read port and
// the one shared multiplier; a stalled o_rsp adds its stalls.
// Reset clears the stack pointer and view origin; matrix memory is not cleared.
module fixed_point_matrix_stack #(
    parameter int STACK_DEPTH   = fpms_pkg::DEF_STACK_DEPTH,
    parameter int FRACTION_BITS = fpms_pkg::DEF_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fpms_req_if.sink                         i_req,
    fpms_rsp_if.source                       o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fpms_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fpms_pkg::VALUE_W-1:0]     pwdata,
    output logic [fpms_pkg::VALUE_W-1:0]     prdata,
    output logic                             pready
);
    import fpms_pkg::*;

    localparam int PTR_W     = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH = STACK_DEPTH * ELEMS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [VALUE_W-1:0] UNIT_VALUE = VALUE_W'(1) << FRACTION_BITS;

    // Configuration registers
    logic [VALUE_W-1:0] r_view_x;
    logic [VALUE_W-1:0] r_view_y;
    logic [VALUE_W-1:0] r_view_z;
    logic               cfg_wr;

    // Sequencer
    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    t_req               in_req;
    logic               r_err;
    logic [3:0]         r_cnt;
    logic [1:0]         r_row;
    logic [PTR_W-1:0]   r_ptr;
    logic               accept;
    logic               full;
    logic               empty;
    logic               null_rot;
    logic               in_err;

    // Latched operands
    logic [VALUE_W-1:0] r_vx;
    logic [VALUE_W-1:0] r_vy;
    logic [VALUE_W-1:0] r_vz;
    logic [VALUE_W-1:0] r_sin;
    logic [VALUE_W-1:0] r_cos;
    logic [VALUE_W-1:0] in_sin;
    logic [VALUE_W-1:0] in_cos;
    logic [VALUE_W-1:0] r_mbuf [ROW_LEN];

    // Memory
    logic [VALUE_W-1:0] r_mem [MEM_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  cur_base;
    logic [ADDR_W-1:0]  nxt_base;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               wr_en;

    // MAC
    t_uop               uop;
    t_mac_ctl           mac_ctl;
    t_mac_wr            mac_wr;
    logic               mac_issue;
    logic [VALUE_W-1:0] mult_a;
    logic [VALUE_W-1:0] mult_b;
    logic [VALUE_W-1:0] mac_init;

    // Output register
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_index;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;
    logic               r_out_error;
    logic [LEVEL_W-1:0] r_out_level;
    logic               out_free;
    logic               out_load;
    logic [IDX_W-1:0]   n_out_index;
    logic [VALUE_W-1:0] n_out_value;
    logic               n_out_last;
    logic               n_out_error;
    logic [PTR_W+LEVEL_W-1:0] level_ext;

    // APB configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x <= '0;
            r_view_y <= '0;
            r_view_z <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(paddr[3:2]))
                REG_VIEW_X: r_view_x <= pwdata;
                REG_VIEW_Y: r_view_y <= pwdata;
                REG_VIEW_Z: r_view_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_reg'(paddr[3:2]))
            REG_VIEW_X: prdata = r_view_x;
            REG_VIEW_Y: prdata = r_view_y;
            REG_VIEW_Z: prdata = r_view_z;
            default:    prdata = '0;
        endcase
    end

    // Input decode
    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign in_req      = t_req'(i_req.req_type);
    assign full        = (r_ptr == PTR_W'(STACK_DEPTH - 1));
    assign empty       = (r_ptr == '0);
    assign in_cos      = {{(VALUE_W-TRIG_W){i_req.cosine_value[TRIG_W-1]}}, i_req.cosine_value};
    assign in_sin      = {{(VALUE_W-TRIG_W){i_req.sine_value[TRIG_W-1]}}, i_req.sine_value};
    assign null_rot    = (in_sin == '0) && (in_cos == UNIT_VALUE);
    assign in_err      = (((in_req == REQ_PUSH) || (in_req == REQ_PUSH_ID)) && full) ||
                         ((in_req == REQ_POP) && empty);

    // Level base addresses: ptr * 12
    assign cur_base = ADDR_W'({r_ptr, 3'b000}) + ADDR_W'({r_ptr, 2'b00});
    assign nxt_base = cur_base + ADDR_W'(ELEMS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_req)
                        REQ_PUSH:    n_state = full ? ST_STATUS : ST_COPY;
                        REQ_PUSH_ID: n_state = full ? ST_STATUS : ST_IDENT;
                        REQ_TRANS_REL, REQ_TRANS_ABS, REQ_SCALE: n_state = ST_ROW_LOAD;
                        REQ_ROT_X, REQ_ROT_Y, REQ_ROT_Z:
                            n_state = null_rot ? ST_STATUS : ST_ROW_LOAD;
                        REQ_READ:    n_state = ST_RD_ISSUE;
                        default:     n_state = ST_STATUS;
                    endcase
                end
            end
            ST_COPY:     if (r_cnt == 4'(ELEMS)) n_state = ST_STATUS;
            ST_IDENT:    if (r_cnt == 4'(ELEMS - 1)) n_state = ST_STATUS;
            ST_ROW_LOAD: if (r_cnt == 4'(ROW_LEN)) n_state = ST_ROW_MAC;
            ST_ROW_MAC: begin
                if (uop.done) begin
                    n_state = (r_row == 2'(ROWS - 1)) ? ST_STATUS : ST_ROW_LOAD;
                end
            end
            ST_RD_ISSUE: n_state = ST_RD_EMIT;
            ST_RD_EMIT: begin
                if (out_free) begin
                    n_state = (r_cnt == 4'(ELEMS - 1)) ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            ST_STATUS:   if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer outputs: memory ports, MAC issue, result load
    assign uop      = uop_decode(r_req, r_cnt[2:0]);
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        rd_addr     = cur_base + ADDR_W'(r_cnt);
        wr_en       = 1'b0;
        wr_addr     = cur_base;
        wr_data     = '0;
        mac_issue   = 1'b0;
        out_load    = 1'b0;
        n_out_index = '0;
        n_out_value = '0;
        n_out_last  = 1'b1;
        n_out_error = r_err;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (in_req == REQ_LOAD) && (i_req.element_index < IDX_W'(ELEMS))) begin
                    wr_en   = 1'b1;
                    wr_addr = cur_base + ADDR_W'(i_req.element_index);
                    wr_data = i_req.element_value;
                end
            end
            ST_COPY: begin
                // read element cnt, write element cnt-1 of the new level
                if (r_cnt != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = nxt_base + ADDR_W'(r_cnt - 4'd1);
                    wr_data = r_rd_data;
                end
            end
            ST_IDENT: begin
                wr_en   = 1'b1;
                wr_addr = nxt_base + ADDR_W'(r_cnt);
                wr_data = ((r_cnt == 4'd0) || (r_cnt == 4'd5) || (r_cnt == 4'd10)) ?
                          UNIT_VALUE : '0;
            end
            ST_ROW_LOAD: rd_addr = cur_base + ADDR_W'({r_row, r_cnt[1:0]});
            ST_ROW_MAC:  mac_issue = 1'b1;
            ST_RD_ISSUE: ;
            ST_RD_EMIT: begin
                out_load    = out_free;
                n_out_index = r_cnt;
                n_out_value = r_rd_data;
                n_out_last  = (r_cnt == 4'(ELEMS - 1));
                n_out_error = 1'b0;
            end
            ST_STATUS:   out_load = out_free;
            default: ;
        endcase
        // MAC write-back lands during the row program, the next row load or the status wait
        if (mac_wr.en) begin
            wr_en   = 1'b1;
            wr_addr = cur_base + ADDR_W'({mac_wr.row, mac_wr.col});
            wr_data = mac_wr.data;
        end
    end

    // Command registers, counters and row buffer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= in_req;
            r_err <= in_err;
            r_cnt <= '0;
            r_row <= '0;
            r_cos <= in_cos;
            r_sin <= (in_req == REQ_ROT_Y) ? (VALUE_W'(0) - in_sin) : in_sin;
            if (in_req == REQ_TRANS_ABS) begin
                r_vx <= i_req.vec_x - r_view_x;
                r_vy <= i_req.vec_y - r_view_y;
                r_vz <= i_req.vec_z - r_view_z;
            end else begin
                r_vx <= i_req.vec_x;
                r_vy <= i_req.vec_y;
                r_vz <= i_req.vec_z;
            end
        end else begin
            case (r_state)
                ST_COPY, ST_IDENT: r_cnt <= r_cnt + 4'd1;
                ST_ROW_LOAD: begin
                    r_cnt <= (r_cnt == 4'(ROW_LEN)) ? 4'd0 : (r_cnt + 4'd1);
                    if (r_cnt != '0) begin
                        r_mbuf[2'(r_cnt - 4'd1)] <= r_rd_data;
                    end
                end
                ST_ROW_MAC: begin
                    if (uop.done) begin
                        r_cnt <= '0;
                        r_row <= r_row + 2'd1;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_RD_EMIT: if (out_free) r_cnt <= r_cnt + 4'd1;
                default: ;
            endcase
        end
    end

    // Stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (accept && (in_req == REQ_POP) && !empty) begin
            r_ptr <= r_ptr - PTR_W'(1);
        end else if (((r_state == ST_COPY) && (r_cnt == 4'(ELEMS))) ||
                     ((r_state == ST_IDENT) && (r_cnt == 4'(ELEMS - 1)))) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end
    end

    // Matrix memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Shared multiply-accumulate unit
    always_comb begin
        mac_ctl.first = uop.first;
        mac_ctl.sub   = uop.sub;
        mac_ctl.wr    = uop.wr;
        mac_ctl.shift = uop.shift;
        mac_ctl.row   = r_row;
        mac_ctl.col   = uop.wcol;
        mult_a        = r_mbuf[uop.src_col];
        case (uop.coef)
            COEF_X:  mult_b = r_vx;
            COEF_Y:  mult_b = r_vy;
            COEF_Z:  mult_b = r_vz;
            COEF_C:  mult_b = r_cos;
            COEF_S:  mult_b = r_sin;
            default: mult_b = '0;
        endcase
        mac_init = (r_req == REQ_TRANS_REL) ? r_mbuf[2'(ROW_LEN - 1)] : '0;
    end

    fpms_mac #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (mac_issue),
        .i_ctl    (mac_ctl),
        .i_mult_a (mult_a),
        .i_mult_b (mult_b),
        .i_init   (mac_init),
        .o_wr     (mac_wr)
    );

    // Result register; the level is captured with the transaction
    assign level_ext = {{LEVEL_W{1'b0}}, r_ptr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= n_out_index;
            r_out_value <= n_out_value;
            r_out_last  <= n_out_last;
            r_out_error <= n_out_error;
            r_out_level <= level_ext[LEVEL_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_index   = r_out_index;
    assign o_rsp.out_value   = r_out_value;
    assign o_rsp.out_last    = r_out_last;
    assign o_rsp.stack_level = r_out_level;
    assign o_rsp.stack_error = r_out_error;

    // MAC write-back never competes with a sequencer write
    a_mac_wr_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_wr.en |-> (r_state == ST_ROW_MAC || r_state == ST_ROW_LOAD ||
                       r_state == ST_STATUS))
        else $error("MAC write-back outside its slot");

    // Stack pointer moves by one step at a time
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_ptr) |-> (r_ptr == PTR_W'($past(r_ptr) + PTR_W'(1)) ||
                             r_ptr == PTR_W'($past(r_ptr) - PTR_W'(1))))
        else $error("stack pointer jumped");

    // Stack pointer only changes on pop acceptance or at the end of a push
    a_ptr_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_ptr) |-> ($past(accept) || $past(r_state) == ST_COPY ||
                             $past(r_state) == ST_IDENT))
        else $error("stack pointer changed without a push or pop");

endmodule
